[hw/rtl/ptfv_pkg.sv]
// ----------------------------------------------------------------------------
// ptfv_pkg
// Shared types, widths and constants for the polar target velocity block.
// ----------------------------------------------------------------------------
package ptfv_pkg;

  localparam int CORDIC_STAGES = 20;
  localparam int ISQRT_STAGES  = 32;

  localparam int POS_W      = 32;
  localparam int GAIN_W     = 24;
  localparam int ANGCFG_W   = 24;
  localparam int LIM_W      = 31;
  localparam int FRAC_W     = 16;
  localparam int CORDIC_W   = 64;
  localparam int SCALE_SH   = 28;
  localparam int Z_W        = 36;
  localparam int ROUND_SH   = 8;
  localparam int ANG_W      = Z_W - ROUND_SH;
  localparam int DIST_W     = 32;
  localparam int SQ_W       = 2 * POS_W;
  localparam int LINP_W     = GAIN_W + DIST_W;
  localparam int LINS_W     = LINP_W - FRAC_W;
  localparam int ANGP_W     = GAIN_W + 1 + ANG_W;
  localparam int ANGS_W     = ANGP_W - FRAC_W;

  localparam int DIST_LAT   = 3 + ISQRT_STAGES;
  localparam int BEAR_LAT   = CORDIC_STAGES + 2;
  localparam int BEAR_PAD   = DIST_LAT - BEAR_LAT;
  localparam int CMD_LAT    = 2;
  localparam int PIPE_LAT   = DIST_LAT + CMD_LAT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_THRESHOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THRESHOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_FIRST_ANGLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_VEL_LIMIT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_VEL_LIMIT      = 3'd7;

  localparam logic signed [Z_W-1:0] DEG180_Q24 = Z_W'(64'd3019898880);

  typedef struct packed {
    logic               point_valid;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] z_pos;
  } in_req_t;

  typedef struct packed {
    logic        [30:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic signed [31:0] gaze_x;
    logic signed [31:0] gaze_y;
    logic signed [31:0] gaze_z;
  } out_rsp_t;

  typedef struct packed {
    logic signed [31:0] gaze_x;
    logic signed [31:0] gaze_y;
    logic signed [31:0] gaze_z;
  } gaze_t;

  typedef struct packed {
    logic                follow_enable;
    logic [GAIN_W-1:0]   dist_gain;
    logic [GAIN_W-1:0]   ang_gain;
    logic [LIM_W-1:0]    dist_threshold;
    logic [ANGCFG_W-1:0] angle_threshold;
    logic [ANGCFG_W-1:0] rotate_first_angle;
    logic [LIM_W-1:0]    lin_vel_limit;
    logic [LIM_W-1:0]    ang_vel_limit;
  } cfg_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd754974720;
      5'd1:  v = 31'd445687602;
      5'd2:  v = 31'd235489088;
      5'd3:  v = 31'd119537938;
      5'd4:  v = 31'd60000934;
      5'd5:  v = 31'd30029717;
      5'd6:  v = 31'd15018523;
      5'd7:  v = 31'd7509720;
      5'd8:  v = 31'd3754917;
      5'd9:  v = 31'd1877466;
      5'd10: v = 31'd938734;
      5'd11: v = 31'd469367;
      5'd12: v = 31'd234684;
      5'd13: v = 31'd117342;
      5'd14: v = 31'd58671;
      5'd15: v = 31'd29335;
      5'd16: v = 31'd14668;
      5'd17: v = 31'd7334;
      5'd18: v = 31'd3667;
      5'd19: v = 31'd1833;
      5'd20: v = 31'd917;
      5'd21: v = 31'd458;
      5'd22: v = 31'd229;
      5'd23: v = 31'd115;
      5'd24: v = 31'd57;
      5'd25: v = 31'd29;
      5'd26: v = 31'd14;
      5'd27: v = 31'd7;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = '0;
    endcase
    return $signed(Z_W'(v));
  endfunction

endpackage

[hw/rtl/ptfv_dist.sv]
// ----------------------------------------------------------------------------
// ptfv_dist
// Planar distance floor(sqrt(x*x + y*y)): abs, square, sum, then one root
// bit per stage.
// ----------------------------------------------------------------------------
module ptfv_dist import ptfv_pkg::*; (
  input  logic                    clk,
  input  logic                    advance,
  input  logic signed [POS_W-1:0] x,
  input  logic signed [POS_W-1:0] y,
  output logic [DIST_W-1:0]       distance
);

  logic [POS_W-1:0] ax;
  logic [POS_W-1:0] ay;
  logic [SQ_W-1:0]  sqx;
  logic [SQ_W-1:0]  sqy;
  logic [SQ_W-1:0]  rem  [ISQRT_STAGES+1];
  logic [SQ_W-1:0]  root [ISQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      ax      <= x[POS_W-1] ? $unsigned(-x) : $unsigned(x);
      ay      <= y[POS_W-1] ? $unsigned(-y) : $unsigned(y);
      sqx     <= SQ_W'(ax) * SQ_W'(ax);
      sqy     <= SQ_W'(ay) * SQ_W'(ay);
      rem[0]  <= sqx + sqy;
      root[0] <= '0;
    end
  end

  for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_root
    localparam logic [SQ_W-1:0] ROOT_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;

    assign trial = root[k] + ROOT_BIT;

    always_ff @(posedge clk) begin
      if (advance) begin
        if (rem[k] >= trial) begin
          rem[k+1]  <= rem[k] - trial;
          root[k+1] <= (root[k] >> 1) + ROOT_BIT;
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k] >> 1;
        end
      end
    end
  end

  assign distance = root[ISQRT_STAGES][DIST_W-1:0];

endmodule

[hw/rtl/ptfv_bearing.sv]
// ----------------------------------------------------------------------------
// ptfv_bearing
// Bearing atan2(y, x) in degrees, signed Q12.16, by a vectoring CORDIC, one
// rotation per stage, padded to the latency of the distance path.
// ----------------------------------------------------------------------------
module ptfv_bearing import ptfv_pkg::*; (
  input  logic                    clk,
  input  logic                    advance,
  input  logic signed [POS_W-1:0] x,
  input  logic signed [POS_W-1:0] y,
  output logic signed [ANG_W-1:0] bearing
);

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [CORDIC_W-1:0] cx   [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] cy   [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]      cz   [CORDIC_STAGES+1];
  logic                       zero [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]      zr;
  logic signed [ANG_W-1:0]    ang;
  logic signed [ANG_W-1:0]    pad  [BEAR_PAD];

  assign xs = {{(CORDIC_W - POS_W - SCALE_SH){x[POS_W-1]}}, x, SCALE_SH'(0)};
  assign ys = {{(CORDIC_W - POS_W - SCALE_SH){y[POS_W-1]}}, y, SCALE_SH'(0)};

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (advance) begin
      zero[0] <= (x == 0) && (y == 0);
      if (x[POS_W-1]) begin
        cx[0] <= -xs;
        cy[0] <= -ys;
        cz[0] <= y[POS_W-1] ? -DEG180_Q24 : DEG180_Q24;
      end else begin
        cx[0] <= xs;
        cy[0] <= ys;
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CORDIC_W-1:0] xsh;
    logic signed [CORDIC_W-1:0] ysh;

    assign xsh = cx[i] >>> i;
    assign ysh = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (advance) begin
        zero[i+1] <= zero[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + ysh;
          cy[i+1] <= cy[i] - xsh;
          cz[i+1] <= cz[i] + atan_q24(5'(i));
        end else begin
          cx[i+1] <= cx[i] - ysh;
          cy[i+1] <= cy[i] + xsh;
          cz[i+1] <= cz[i] - atan_q24(5'(i));
        end
      end
    end
  end

  assign zr = cz[CORDIC_STAGES] + Z_W'(128);

  always_ff @(posedge clk) begin
    if (advance) begin
      ang    <= zero[CORDIC_STAGES] ? '0 : $signed(zr[Z_W-1:ROUND_SH]);
      pad[0] <= ang;
      for (int k = 1; k < BEAR_PAD; k++) begin
        pad[k] <= pad[k-1];
      end
    end
  end

  assign bearing = pad[BEAR_PAD-1];

endmodule

[hw/rtl/ptfv_cmd.sv]
// ----------------------------------------------------------------------------
// ptfv_cmd
// Velocity command: gain products and deadband tests, then shift, rotate-
// first gating and saturation.
// ----------------------------------------------------------------------------
module ptfv_cmd import ptfv_pkg::*; (
  input  logic                    clk,
  input  logic                    advance,
  input  cfg_t                    cfg,
  input  logic [DIST_W-1:0]       distance,
  input  logic signed [ANG_W-1:0] bearing,
  output logic [LIM_W-1:0]        lin_vel,
  output logic signed [31:0]      ang_vel
);

  logic [ANG_W-1:0]         abs_ang;
  logic                     outside_c;
  logic [LINP_W-1:0]        lin_prod;
  logic signed [ANGP_W-1:0] ang_prod;
  logic                     dist_ok;
  logic                     outside;
  logic                     rot_first;
  logic [LINS_W-1:0]        lin_gated;
  logic signed [ANGS_W-1:0] ang_gated;
  logic signed [ANGS_W-1:0] ang_lim;

  assign abs_ang   = bearing[ANG_W-1] ? $unsigned(-bearing) : $unsigned(bearing);
  assign outside_c = abs_ang > ANG_W'(cfg.angle_threshold);

  always_ff @(posedge clk) begin
    if (advance) begin
      lin_prod  <= LINP_W'(cfg.dist_gain) * LINP_W'(distance);
      ang_prod  <= ANGP_W'($signed({1'b0, cfg.ang_gain})) * ANGP_W'(bearing);
      dist_ok   <= distance > DIST_W'(cfg.dist_threshold);
      outside   <= outside_c;
      rot_first <= outside_c && (abs_ang < ANG_W'(cfg.rotate_first_angle));
    end
  end

  assign lin_gated = (dist_ok && !rot_first) ? lin_prod[LINP_W-1:FRAC_W] : '0;
  assign ang_gated = outside ? $signed(ang_prod[ANGP_W-1:FRAC_W]) : '0;
  assign ang_lim   = $signed(ANGS_W'(cfg.ang_vel_limit));

  always_ff @(posedge clk) begin
    if (advance) begin
      if (lin_gated > LINS_W'(cfg.lin_vel_limit)) begin
        lin_vel <= cfg.lin_vel_limit;
      end else begin
        lin_vel <= lin_gated[LIM_W-1:0];
      end
      if (ang_gated > ang_lim) begin
        ang_vel <= ang_lim[31:0];
      end else if (ang_gated < -ang_lim) begin
        ang_vel <= 32'(-ang_lim);
      end else begin
        ang_vel <= ang_gated[31:0];
      end
    end
  end

endmodule

[hw/rtl/polar_target_follow_velocity.sv]
// ----------------------------------------------------------------------------
// polar_target_follow_velocity
// Velocity command toward a target point given in the robot base frame.
//
// Requests arrive on in_valid/in_ready/in_data. A request whose point_valid
// is set while follow_enable is set yields one result on
// out_valid/out_ready/out_data; any other request is taken and dropped.
// Registers are written via cfg_we/cfg_index/cfg_wdata, one per cycle; the
// user must write only while no request is in flight; block won't enforce.
// Results pass through the input register, the square root pipeline (32
// stages, one root bit each), the command stages and the output register.
// The bearing CORDIC runs alongside in fewer stages.
// Throughput is one request per cycle while the skid register is empty.
// When out_ready is held low, an output register and a skid register hold
// up to two results; in_ready drops as soon as the skid register fills and
// the whole pipeline holds until it drains.
// Reset clears the configuration and the valid flags, emptying the pipeline.
// ----------------------------------------------------------------------------
module polar_target_follow_velocity import ptfv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_rsp_t              out_data
);

  cfg_t                    cfg;
  logic                    advance;
  logic                    s1_valid;
  logic signed [POS_W-1:0] s1_x;
  logic signed [POS_W-1:0] s1_y;
  logic signed [POS_W-1:0] s1_z;
  logic [PIPE_LAT-1:0]     line_valid;
  gaze_t                   line_gaze [PIPE_LAT];
  logic [DIST_W-1:0]       distance;
  logic signed [ANG_W-1:0] bearing;
  logic [LIM_W-1:0]        lin_vel;
  logic signed [31:0]      ang_vel;
  logic                    last_valid;
  out_rsp_t                last_rsp;
  logic                    skid_valid;
  out_rsp_t                skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOLLOW_ENABLE:      cfg.follow_enable      <= cfg_wdata[0];
        REG_DIST_GAIN:          cfg.dist_gain          <= cfg_wdata[GAIN_W-1:0];
        REG_ANG_GAIN:           cfg.ang_gain           <= cfg_wdata[GAIN_W-1:0];
        REG_DIST_THRESHOLD:     cfg.dist_threshold     <= cfg_wdata[LIM_W-1:0];
        REG_ANGLE_THRESHOLD:    cfg.angle_threshold    <= cfg_wdata[ANGCFG_W-1:0];
        REG_ROTATE_FIRST_ANGLE: cfg.rotate_first_angle <= cfg_wdata[ANGCFG_W-1:0];
        REG_LIN_VEL_LIMIT:      cfg.lin_vel_limit      <= cfg_wdata[LIM_W-1:0];
        REG_ANG_VEL_LIMIT:      cfg.ang_vel_limit      <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !skid_valid;
  assign in_ready = advance;

  // drop requests that produce no command
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      line_valid <= '0;
    end else if (advance) begin
      s1_valid   <= in_valid && in_data.point_valid && cfg.follow_enable;
      line_valid <= {line_valid[PIPE_LAT-2:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x                <= in_data.x_pos;
      s1_y                <= in_data.y_pos;
      s1_z                <= in_data.z_pos;
      line_gaze[0].gaze_x <= s1_x;
      line_gaze[0].gaze_y <= s1_y;
      line_gaze[0].gaze_z <= s1_z;
      for (int k = 1; k < PIPE_LAT; k++) begin
        line_gaze[k] <= line_gaze[k-1];
      end
    end
  end

  ptfv_dist u_dist (
    .clk      (clk),
    .advance  (advance),
    .x        (s1_x),
    .y        (s1_y),
    .distance (distance)
  );

  ptfv_bearing u_bearing (
    .clk     (clk),
    .advance (advance),
    .x       (s1_x),
    .y       (s1_y),
    .bearing (bearing)
  );

  ptfv_cmd u_cmd (
    .clk      (clk),
    .advance  (advance),
    .cfg      (cfg),
    .distance (distance),
    .bearing  (bearing),
    .lin_vel  (lin_vel),
    .ang_vel  (ang_vel)
  );

  assign last_valid = line_valid[PIPE_LAT-1];

  always_comb begin
    last_rsp.linear_velocity  = lin_vel;
    last_rsp.angular_velocity = ang_vel;
    last_rsp.gaze_x           = line_gaze[PIPE_LAT-1].gaze_x;
    last_rsp.gaze_y           = line_gaze[PIPE_LAT-1].gaze_y;
    last_rsp.gaze_z           = line_gaze[PIPE_LAT-1].gaze_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= last_valid;
    end else if (last_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || out_ready) begin
      if (last_valid) begin
        out_data <= last_rsp;
      end
    end else begin
      skid_data <= last_rsp;
    end
  end

endmodule

[hw/rtl/ptfv_checker.sv]
// ----------------------------------------------------------------------------
// ptfv_checker
// Port-level checks on the output channel and the stall path.
// ----------------------------------------------------------------------------
module ptfv_checker import ptfv_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_rsp_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("request side stalled without a blocked result");

endmodule

bind polar_target_follow_velocity ptfv_checker u_checker (.*);

[bench/tb_polar_target_follow_velocity.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_target_follow_velocity
// Self-checking bench for the polar target velocity block. A table of
// directed points and register writes runs first, then random phases, each
// with its own register setting. Every accepted request goes through a
// local model of the distance, CORDIC bearing, deadband, rotate-first and
// clamp logic. Each result is compared field by field with the oldest
// pending command. Both handshakes idle at random, and one phase holds the
// output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_polar_target_follow_velocity import ptfv_pkg::*; ();

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_FIXED, ROW_NONE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    in_req_t               req;
    out_rsp_t              rsp;
  } dir_row_t;

  localparam longint ATAN_Q24 [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };
  localparam longint HALF_TURN_Q24 = 64'sd3019898880;
  localparam longint CORDIC_SCALE  = 64'sd268435456;
  localparam logic [31:0] ONE_M    = 32'h0001_0000;
  localparam int PHASES            = 9;
  localparam int PHASE_CMDS        = 100;
  localparam int LONG_HOLD         = 400;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_rsp_t              out_data;

  cfg_t     follow_regs;
  out_rsp_t pending_cmds [$];
  dir_row_t dir_tab [$];
  int       err_count;
  bit       src_idle;
  bit       sink_idle;
  int       holds_asked;
  int       holds_done;

  polar_target_follow_velocity u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint bearing_deg_q16(input longint px, input longint py);
    longint vx;
    longint vy;
    longint acc;
    longint sx;
    longint sy;
    int     i;
    if (px == 0 && py == 0) return 0;
    vx = px * CORDIC_SCALE;
    vy = py * CORDIC_SCALE;
    acc = 0;
    if (vx < 0) begin
      acc = (vy >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
      vx = -vx;
      vy = -vy;
    end
    for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx = vx + sy;
        vy = vy - sx;
        acc = acc + ATAN_Q24[i];
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        acc = acc - ATAN_Q24[i];
      end
    end
    return (acc + 128) >>> 8;
  endfunction

  function automatic bit predict_command(input in_req_t req, output out_rsp_t rsp);
    longint          px;
    longint          py;
    longint          ax;
    longint          ay;
    longint          bear;
    longint          abs_bear;
    longint          turn;
    longint          turn_lim;
    longint unsigned distance;
    longint unsigned fwd;
    bit              turning;
    rsp = '0;
    if (!req.point_valid || !follow_regs.follow_enable) return 1'b0;
    px = longint'(req.x_pos);
    py = longint'(req.y_pos);
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    distance = floor_sqrt(longint'(ax * ax) + longint'(ay * ay));
    bear = bearing_deg_q16(px, py);
    abs_bear = (bear < 0) ? -bear : bear;
    fwd = 0;
    if (distance > follow_regs.dist_threshold)
      fwd = (longint'(follow_regs.dist_gain) * distance) >> 16;
    turning = abs_bear > longint'(follow_regs.angle_threshold);
    turn = 0;
    if (turning) turn = (longint'(follow_regs.ang_gain) * bear) >>> 16;
    if (turning && abs_bear < longint'(follow_regs.rotate_first_angle)) fwd = 0;
    turn_lim = longint'(follow_regs.ang_vel_limit);
    if (turn > turn_lim) turn = turn_lim;
    if (turn < -turn_lim) turn = -turn_lim;
    if (fwd > follow_regs.lin_vel_limit) fwd = follow_regs.lin_vel_limit;
    rsp.linear_velocity  = fwd[30:0];
    rsp.angular_velocity = turn[31:0];
    rsp.gaze_x = req.x_pos;
    rsp.gaze_y = req.y_pos;
    rsp.gaze_z = req.z_pos;
    return 1'b1;
  endfunction

  function automatic int draw_gap(input bit on);
    return on ? $urandom_range(0, 15) : 0;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic dir_row_t pt_row(input row_kind_e k, input logic v,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z,
                                      input logic [30:0] lin = '0,
                                      input logic [31:0] ang = '0);
    dir_row_t r;
    r = '0;
    r.kind = k;
    r.req  = '{point_valid: v, x_pos: x, y_pos: y, z_pos: z};
    r.rsp  = '{linear_velocity: lin, angular_velocity: ang,
               gaze_x: x, gaze_y: y, gaze_z: z};
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int ph,
                                                     input logic [CFG_DATA_W-1:0] top,
                                                     input logic [CFG_DATA_W-1:0] typical);
    int sel;
    sel = (ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(0, 7);
    case (sel)
      0:       return '0;
      1:       return top;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, typical));
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
      4, 5:       return $urandom;
      6:          return '0;
      7:          return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:    return (32'($urandom_range(0, 20)) - 32'd10) << 16;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FOLLOW_ENABLE:      follow_regs.follow_enable      = data[0];
      REG_DIST_GAIN:          follow_regs.dist_gain          = data[GAIN_W-1:0];
      REG_ANG_GAIN:           follow_regs.ang_gain           = data[GAIN_W-1:0];
      REG_DIST_THRESHOLD:     follow_regs.dist_threshold     = data[LIM_W-1:0];
      REG_ANGLE_THRESHOLD:    follow_regs.angle_threshold    = data[ANGCFG_W-1:0];
      REG_ROTATE_FIRST_ANGLE: follow_regs.rotate_first_angle = data[ANGCFG_W-1:0];
      REG_LIN_VEL_LIMIT:      follow_regs.lin_vel_limit      = data[LIM_W-1:0];
      REG_ANG_VEL_LIMIT:      follow_regs.ang_vel_limit      = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // drop valid, drain pending commands, let dropped requests leave the pipe
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic send_point(input in_req_t req, input row_kind_e kind,
                            input out_rsp_t fixed_rsp, output bit produced);
    int       gap;
    out_rsp_t rsp;
    gap = draw_gap(src_idle);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    produced = predict_command(req, rsp);
    if (kind == ROW_FIXED) pending_cmds.push_back(fixed_rsp);
    else if (kind == ROW_PREDICT && produced) pending_cmds.push_back(rsp);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // receiver: random hold-off per result, one long hold when asked
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        stall = LONG_HOLD;
        holds_done++;
      end else begin
        stall = draw_gap(sink_idle);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        err_count++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("linear_velocity", 32'(want.linear_velocity),
                    32'(out_data.linear_velocity));
        check_field("angular_velocity", want.angular_velocity, out_data.angular_velocity);
        check_field("gaze_x", want.gaze_x, out_data.gaze_x);
        check_field("gaze_y", want.gaze_y, out_data.gaze_y);
        check_field("gaze_z", want.gaze_z, out_data.gaze_z);
      end
    end
  end

  initial begin
    in_req_t req;
    bit      produced;
    int      cmds;
    int      sent;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_FOLLOW_ENABLE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    follow_regs = '0;
    err_count   = 0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    holds_asked = 0;
    holds_done  = 0;

    // disabled after reset, then enabled with zero gains and limits
    dir_tab.push_back(pt_row(ROW_NONE, 1'b1, ONE_M, 32'h0, 32'h0));
    dir_tab.push_back(cfg_row(REG_FOLLOW_ENABLE, 31'd1));
    dir_tab.push_back(pt_row(ROW_FIXED, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h5555_5555));
    dir_tab.push_back(pt_row(ROW_NONE, 1'b0, 32'hFFFF_FFFF, ONE_M, 32'h0));
    // unit gains, no deadbands, full limits
    dir_tab.push_back(cfg_row(REG_DIST_GAIN, 31'h1_0000));
    dir_tab.push_back(cfg_row(REG_ANG_GAIN, 31'h1_0000));
    dir_tab.push_back(cfg_row(REG_LIN_VEL_LIMIT, 31'h7FFF_FFFF));
    dir_tab.push_back(cfg_row(REG_ANG_VEL_LIMIT, 31'h7FFF_FFFF));
    dir_tab.push_back(pt_row(ROW_FIXED, 1'b1, 32'h0, 32'h0, 32'h1234_5678));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, ONE_M, 32'h0, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, 32'h0, ONE_M, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, -ONE_M, 32'h0, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, -ONE_M, 32'hFFFF_FFFF, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF));
    // 1 m distance deadband, 10 deg angle deadband, rotate first below 45 deg
    dir_tab.push_back(cfg_row(REG_DIST_THRESHOLD, 31'h1_0000));
    dir_tab.push_back(cfg_row(REG_ANGLE_THRESHOLD, 31'd655360));
    dir_tab.push_back(cfg_row(REG_ROTATE_FIRST_ANGLE, 31'd2949120));
    dir_tab.push_back(pt_row(ROW_FIXED, 1'b1, ONE_M, 32'h0, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, 32'h2_0000, 32'h8000, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, ONE_M, 32'h2_0000, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, 32'h2_0000, 32'hFFFF_CCCD, 32'h0));
    // saturation both ways
    dir_tab.push_back(cfg_row(REG_ROTATE_FIRST_ANGLE, 31'd0));
    dir_tab.push_back(cfg_row(REG_DIST_GAIN, 31'hFF_FFFF));
    dir_tab.push_back(cfg_row(REG_ANG_GAIN, 31'hFF_FFFF));
    dir_tab.push_back(cfg_row(REG_LIN_VEL_LIMIT, 31'h8000));
    dir_tab.push_back(cfg_row(REG_ANG_VEL_LIMIT, 31'h5_0000));
    dir_tab.push_back(pt_row(ROW_FIXED, 1'b1, 32'hA_0000, 32'hA_0000, 32'h0,
                             31'h8000, 32'h0005_0000));
    dir_tab.push_back(pt_row(ROW_FIXED, 1'b1, 32'hA_0000, 32'hFFF6_0000, 32'h0,
                             31'h8000, 32'hFFFB_0000));
    // deadbands at their maxima
    dir_tab.push_back(cfg_row(REG_ANGLE_THRESHOLD, 31'd11796480));
    dir_tab.push_back(cfg_row(REG_ROTATE_FIRST_ANGLE, 31'd11796480));
    dir_tab.push_back(cfg_row(REG_DIST_THRESHOLD, 31'h7FFF_FFFF));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, -ONE_M, 32'h0, 32'h0));
    dir_tab.push_back(pt_row(ROW_PREDICT, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    dir_tab.push_back(cfg_row(REG_FOLLOW_ENABLE, 31'd0));
    dir_tab.push_back(pt_row(ROW_NONE, 1'b1, 32'h8000_0000, 32'h0, 32'h0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[k].idx, dir_tab[k].wdata);
      end else begin
        send_point(dir_tab[k].req, dir_tab[k].kind, dir_tab[k].rsp, produced);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(REG_FOLLOW_ENABLE, {(CFG_DATA_W-1)'($urandom), ph != 4});
      write_reg(REG_DIST_GAIN, pick_reg(ph, 31'hFF_FFFF, 31'h4_0000));
      write_reg(REG_ANG_GAIN, pick_reg(ph, 31'hFF_FFFF, 31'h2_0000));
      write_reg(REG_DIST_THRESHOLD, pick_reg(ph, 31'h7FFF_FFFF, 31'h4_0000));
      write_reg(REG_ANGLE_THRESHOLD, pick_reg(ph, 31'd11796480, 31'd1966080));
      write_reg(REG_ROTATE_FIRST_ANGLE, pick_reg(ph, 31'd11796480, 31'd5898240));
      write_reg(REG_LIN_VEL_LIMIT, pick_reg(ph, 31'h7FFF_FFFF, 31'h10_0000));
      write_reg(REG_ANG_VEL_LIMIT, pick_reg(ph, 31'h7FFF_FFFF, 31'h100_0000));
      src_idle  = (ph % 3 != 1);
      sink_idle = (ph % 3 != 2);
      // hold the output off while requests keep coming
      if (ph == 5) begin
        src_idle = 1'b0;
        holds_asked++;
      end
      cmds = 0;
      sent = 0;
      while (follow_regs.follow_enable ? (cmds < PHASE_CMDS) : (sent < 30)) begin
        req.point_valid = ($urandom_range(0, 9) != 0);
        req.x_pos = pick_coord();
        req.y_pos = pick_coord();
        req.z_pos = $urandom;
        send_point(req, ROW_PREDICT, '0, produced);
        if (produced) cmds++;
        sent++;
      end
    end

    settle();
    if (err_count == 0 && pending_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
